>>> sv/jtag_scan_sequencer_core_macros.svh
// assertion macros for the jtag scan sequencer core
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef JTAG_SCAN_SEQUENCER_CORE_MACROS_SVH
`define JTAG_SCAN_SEQUENCER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define JSS_ASSERT_IMPL(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("jss implication check failed");
`define JSS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("jss next-cycle check failed");
`else
`define JSS_ASSERT_IMPL(lbl, clk, rst, pre, post)
`define JSS_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

>>> sv/jss_pkg.sv
// shared types and constants for the jtag scan sequencer core
// no dependencies
`default_nettype none
package jss_pkg;
   localparam int MAX_SCAN_BITS = 32;
   localparam int RESET_CLOCKS  = 8;
   localparam int SCAN_W        = 32;
   localparam int CNT_W         = 6;
   localparam int LEN_W         = 6;
   localparam int IDX_W         = $clog2(MAX_SCAN_BITS);
   localparam int REQ_DATA_W    = 40;
   localparam int REQ_USER_W    = 4;
   localparam int RSP_DATA_W    = 40;

   typedef enum logic [2:0] {
      OP_RESET   = 3'd0,
      OP_IDLE    = 3'd1,
      OP_SEL_DR  = 3'd2,
      OP_P_IDLE  = 3'd3,
      OP_P_SEL   = 3'd4,
      OP_DR      = 3'd5,
      OP_IR      = 3'd6
   } cmd_type;

   typedef struct packed {
      logic              running;
      cmd_type           cmd;
      logic [CNT_W-1:0]  cycle;
      logic [LEN_W-1:0]  len;
      logic [SCAN_W-1:0] shift;
      logic [SCAN_W-1:0] cap;
   } state_type;

   typedef struct packed {
      logic [SCAN_W-1:0] captured;
      logic              done_res;
      logic              busy_res;
      logic              tdi_level;
      logic              tms_level;
      logic              tck_pulse;
   } result_type;
endpackage
`default_nettype wire

>>> sv/jss_step.sv
// next-state and result logic for one tck period of the scan sequencer
// depends on jss_pkg
`default_nettype none
module jss_step (
   input  wire jss_pkg::state_type           state_cur,
   input  wire logic                         start_req,
   input  wire logic [2:0]                   opcode,
   input  wire logic [jss_pkg::SCAN_W-1:0]   scan_value,
   input  wire logic [jss_pkg::LEN_W-1:0]    scan_length,
   input  wire logic                         tdo_level,
   output jss_pkg::state_type                state_nxt,
   output jss_pkg::result_type               result
);
   logic                         active;
   jss_pkg::cmd_type             cmd;
   logic [jss_pkg::CNT_W-1:0]    cyc;
   logic [jss_pkg::LEN_W-1:0]    len_sat;
   logic [jss_pkg::LEN_W-1:0]    len;
   logic [jss_pkg::SCAN_W-1:0]   sh;
   logic [jss_pkg::SCAN_W-1:0]   cap;
   logic [jss_pkg::CNT_W-1:0]    pre;
   logic [jss_pkg::CNT_W-1:0]    total;
   logic [jss_pkg::CNT_W-1:0]    bit_pos;
   logic                         is_scan;
   logic                         shift_hit;
   logic                         last;
   logic                         tms;
   logic [jss_pkg::SCAN_W-1:0]   cap_nxt;

   always_comb begin
      if (scan_length == '0) begin
         len_sat = jss_pkg::LEN_W'(1);
      end else if (scan_length > jss_pkg::LEN_W'(jss_pkg::MAX_SCAN_BITS)) begin
         len_sat = jss_pkg::LEN_W'(jss_pkg::MAX_SCAN_BITS);
      end else begin
         len_sat = scan_length;
      end

      active = state_cur.running ||
               (start_req && (opcode <= 3'(jss_pkg::OP_IR)));
      cmd    = state_cur.running ? state_cur.cmd   : jss_pkg::cmd_type'(opcode);
      cyc    = state_cur.running ? state_cur.cycle : '0;
      len    = state_cur.running ? state_cur.len   : len_sat;
      sh     = state_cur.running ? state_cur.shift : scan_value;
      cap    = state_cur.running ? state_cur.cap   : '0;

      is_scan = (cmd == jss_pkg::OP_DR) || (cmd == jss_pkg::OP_IR);
      pre     = (cmd == jss_pkg::OP_IR) ? jss_pkg::CNT_W'(3) : jss_pkg::CNT_W'(2);

      case (cmd)
         jss_pkg::OP_RESET:  total = jss_pkg::CNT_W'(jss_pkg::RESET_CLOCKS);
         jss_pkg::OP_IDLE,
         jss_pkg::OP_SEL_DR: total = jss_pkg::CNT_W'(1);
         jss_pkg::OP_P_IDLE,
         jss_pkg::OP_P_SEL:  total = jss_pkg::CNT_W'(3);
         default:            total = pre + jss_pkg::CNT_W'(len) + jss_pkg::CNT_W'(1);
      endcase

      bit_pos   = cyc - pre;
      shift_hit = is_scan && (cyc >= pre) &&
                  (cyc < (pre + jss_pkg::CNT_W'(len)));

      case (cmd)
         jss_pkg::OP_RESET,
         jss_pkg::OP_SEL_DR,
         jss_pkg::OP_P_SEL:  tms = 1'b1;
         jss_pkg::OP_IDLE:   tms = 1'b0;
         jss_pkg::OP_P_IDLE: tms = (cyc < jss_pkg::CNT_W'(2));
         default: begin
            if ((cmd == jss_pkg::OP_IR) && (cyc == '0)) begin
               tms = 1'b1;
            end else if (shift_hit) begin
               tms = ((bit_pos + jss_pkg::CNT_W'(1)) == jss_pkg::CNT_W'(len));
            end else begin
               tms = 1'b0;
            end
         end
      endcase

      cap_nxt = cap;
      if (shift_hit) begin
         cap_nxt[bit_pos[jss_pkg::IDX_W-1:0]] = tdo_level;
      end

      last = ((cyc + jss_pkg::CNT_W'(1)) >= total);

      state_nxt = state_cur;
      if (active) begin
         state_nxt.running = !last;
         state_nxt.cmd     = cmd;
         state_nxt.cycle   = last ? '0 : (cyc + jss_pkg::CNT_W'(1));
         state_nxt.len     = len;
         state_nxt.shift   = shift_hit ? (sh >> 1) : sh;
         state_nxt.cap     = cap_nxt;
      end

      result.tck_pulse = active;
      result.tms_level = active && tms;
      result.tdi_level = active && shift_hit && sh[0];
      result.busy_res  = active && !last;
      result.done_res  = active && last;
      result.captured  = (active && last && is_scan) ? cap_nxt : '0;
   end
endmodule
`default_nettype wire

>>> sv/jtag_scan_sequencer_core.sv
// jtag scan sequencer core: a tap master that drives tms/tdi one tck period per transaction
// depends on jss_pkg, jss_step and jtag_scan_sequencer_core_macros.svh
//
// usage:
//   each req transaction is one tck period and carries the sampled tdo level; while
//   idle, start_req with a valid opcode loads a command and that transaction is its
//   first tck cycle. each req transaction yields exactly one rsp transaction with the
//   tck/tms/tdi levels for that period, busy/done flags and, on the done period of a
//   dr or ir scan, the captured tdo word.
//   latency: the rsp transaction is valid the cycle after its req transaction.
//   throughput: one transaction per clock; the single result register is refilled
//   in the same cycle it is taken, so req_tready stays high while rsp_tready is high.
//   when the receiver stalls, the result register holds and req_tready drops until
//   the pending rsp transaction is taken; no transaction is lost or duplicated.
//   reset: synchronous, active high; clears the sequencer to idle with no pending rsp.
`default_nettype none
`include "jtag_scan_sequencer_core_macros.svh"
module jtag_scan_sequencer_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // scan_value[31:0], scan_length[37:32], tdo_level[38]
   input  wire logic [jss_pkg::REQ_DATA_W-1:0]   req_tdata,
   // start_req[0], opcode[3:1]
   input  wire logic [jss_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tck_pulse[0], tms_level[1], tdi_level[2], busy_res[3], done_res[4], captured[36:5]
   output logic [jss_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   jss_pkg::state_type  state_ff;
   jss_pkg::state_type  state_in;
   jss_pkg::result_type result_in;
   jss_pkg::result_type result_ff;
   logic                rsp_valid_ff;
   logic                req_acc;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;

   jss_step u_step (
      .state_cur   (state_ff),
      .start_req   (req_tuser[0]),
      .opcode      (req_tuser[3:1]),
      .scan_value  (req_tdata[31:0]),
      .scan_length (req_tdata[37:32]),
      .tdo_level   (req_tdata[38]),
      .state_nxt   (state_in),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.running <= 1'b0;
         state_ff.cmd     <= jss_pkg::OP_RESET;
         state_ff.cycle   <= '0;
         state_ff.len     <= jss_pkg::LEN_W'(1);
         state_ff.shift   <= '0;
         state_ff.cap     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else if (req_acc) begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, result_ff};

   `JSS_ASSERT_IMPL(a_stall_blocks_req, clock, reset, rsp_valid_ff && !rsp_tready, !req_tready)
   `JSS_ASSERT_NEXT(a_acc_gives_rsp, clock, reset, req_acc, rsp_valid_ff)
   `JSS_ASSERT_IMPL(a_done_not_busy, clock, reset, rsp_valid_ff && result_ff.done_res, !result_ff.busy_res)
   `JSS_ASSERT_IMPL(a_running_counted, clock, reset, state_ff.running, state_ff.cycle != '0)
endmodule
`default_nettype wire
